@@ src/isc_pkg.sv @@
// Shared types, constants and pixel arithmetic of the interpolated 2x scaler.
package isc_pkg;

  localparam int MaxWidthDefault  = 512;
  localparam int MaxHeightDefault = 512;
  localparam int QueueDepth       = 4;
  localparam int OutDepth         = 2;

  localparam int PixW    = 32;
  localparam int SrcIdxW = 9;
  localparam int CfgDimW = 10;
  localparam int CfgFmtW = 2;
  localparam int CfgIdxW = 2;
  localparam int GrpN    = 4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgPixelFormat = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 2'd2;

  // Pixel format codes; any other code is 32-bit.
  localparam logic [CfgFmtW-1:0] FmtRgb555 = 2'd0;
  localparam logic [CfgFmtW-1:0] FmtRgb565 = 2'd1;
  localparam logic [CfgFmtW-1:0] Fmt32     = 2'd2;

  localparam logic [CfgFmtW-1:0] FmtReset    = FmtRgb565;
  localparam logic [CfgDimW-1:0] WidthReset  = 10'd320;
  localparam logic [CfgDimW-1:0] HeightReset = 10'd224;

  localparam logic [PixW-1:0] MaskRgb555 = 32'h0000_3DEF;
  localparam logic [PixW-1:0] MaskRgb565 = 32'h0000_7BEF;
  localparam logic [PixW-1:0] Mask32     = 32'h7F7F_7F7F;

  // Group slots of one source pixel, in output order.
  localparam int GrpUpLeft   = 0;  // (col-1, row-1)
  localparam int GrpUpEdge   = 1;  // (col,   row-1), right edge
  localparam int GrpLeftLast = 2;  // (col-1, row),   bottom row
  localparam int GrpCorner   = 3;  // (col,   row),   last pixel of frame

  // Everything the back end needs to emit the groups of one source pixel.
  typedef struct packed {
    logic [GrpN-1:0]    grp_mask;
    logic [SrcIdxW-1:0] col;
    logic [SrcIdxW-1:0] col_m1;
    logic [SrcIdxW-1:0] row;
    logic [SrcIdxW-1:0] row_m1;
    logic [PixW-1:0]    pix;
    logic [PixW-1:0]    up;
    logic [PixW-1:0]    left;
    logic [PixW-1:0]    up_left;
  } grp_bundle_t;

  typedef struct packed {
    logic [SrcIdxW-1:0] src_col;
    logic [SrcIdxW-1:0] src_row;
    logic [PixW-1:0]    top_left;
    logic [PixW-1:0]    top_right;
    logic [PixW-1:0]    bottom_left;
    logic [PixW-1:0]    bottom_right;
    logic               last_in_run;
  } result_t;

  function automatic logic [PixW-1:0] fmt_mask(input logic [CfgFmtW-1:0] fmt);
    logic [PixW-1:0] m;
    m = Mask32;
    if (fmt == FmtRgb555) m = MaskRgb555;
    else if (fmt == FmtRgb565) m = MaskRgb565;
    return m;
  endfunction

  function automatic logic [PixW-1:0] halve(input logic [PixW-1:0] v,
                                            input logic [PixW-1:0] m);
    return (v >> 1) & m;
  endfunction

  function automatic logic [PixW-1:0] mix(input logic [PixW-1:0] a,
                                          input logic [PixW-1:0] b,
                                          input logic [PixW-1:0] m);
    return halve(a, m) + halve(b, m);
  endfunction

endpackage

@@ src/isc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module isc_ram #(
  parameter int Width = 32,
  parameter int Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/isc_queue.sv @@
// Small flip-flop FIFO used between the scaler's stages.
module isc_queue #(
  parameter int Width = 32,
  parameter int Depth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [Width-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [Width-1:0]           rdata_o,
  output logic                       empty_o,
  output logic                       full_o,
  output logic [$clog2(Depth+1)-1:0] level_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int LvlW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [LvlW-1:0]  level_q, level_d;
  logic             do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    level_d  = level_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      level_d = level_q + LvlW'(1);
    end else if (do_pop && !do_push) begin
      level_d = level_q - LvlW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign empty_o = (level_q == '0);
  assign full_o  = (level_q == LvlW'(Depth));
  assign level_o = level_q;

endmodule

@@ src/isc_front.sv @@
// Front end: accept pixels, track position, keep the previous row, classify groups.
module isc_front #(
  parameter int MaxWidth  = isc_pkg::MaxWidthDefault,
  parameter int MaxHeight = isc_pkg::MaxHeightDefault,
  parameter int QDepth    = isc_pkg::QueueDepth
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               restart_i,
  input  logic [isc_pkg::CfgFmtW-1:0]        fmt_i,
  input  logic [isc_pkg::CfgDimW-1:0]        frame_width_i,
  input  logic [isc_pkg::CfgDimW-1:0]        frame_height_i,
  input  logic                               push_i,
  input  logic [isc_pkg::PixW-1:0]           src_pixel_i,
  output logic                               full_o,
  input  logic [$clog2(QDepth+1)-1:0]        q_level_i,
  output logic                               bnd_push_o,
  output isc_pkg::grp_bundle_t               bnd_o
);

  localparam int CW   = $clog2(MaxWidth);
  localparam int RW   = $clog2(MaxHeight);
  localparam int WWa  = $clog2(MaxWidth + 1);
  localparam int HWa  = $clog2(MaxHeight + 1);
  localparam int WW   = (WWa > isc_pkg::CfgDimW) ? WWa : isc_pkg::CfgDimW;
  localparam int HW   = (HWa > isc_pkg::CfgDimW) ? HWa : isc_pkg::CfgDimW;
  localparam int QLW  = $clog2(QDepth + 1);

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [WW-1:0] w_ext, w_eff;
  logic [HW-1:0] h_ext, h_eff;
  logic          last_col, last_row, accept;
  logic [QLW:0]  occupancy;
  logic [isc_pkg::PixW-1:0] pix_in;

  logic                     s1_valid_q;
  logic [CW-1:0]            s1_col_q;
  logic [RW-1:0]            s1_row_q;
  logic [isc_pkg::PixW-1:0] s1_pix_q;
  logic                     s1_last_col_q, s1_last_row_q;
  logic [isc_pkg::PixW-1:0] ram_rdata, up;
  logic [isc_pkg::PixW-1:0] left_q, up_left_q;
  logic [isc_pkg::GrpN-1:0] mask;

  // Clamp the frame size to MaxWidth and MaxHeight; a zero size acts as one.
  always_comb begin
    w_ext = WW'(frame_width_i);
    h_ext = HW'(frame_height_i);
    if (w_ext == '0) w_eff = WW'(1);
    else if (w_ext > WW'(MaxWidth)) w_eff = WW'(MaxWidth);
    else w_eff = w_ext;
    if (h_ext == '0) h_eff = HW'(1);
    else if (h_ext > HW'(MaxHeight)) h_eff = HW'(MaxHeight);
    else h_eff = h_ext;
  end

  assign last_col = (WW'(col_q) == w_eff - WW'(1));
  assign last_row = (HW'(row_q) == h_eff - HW'(1));

  // Reserve a queue slot for the item still in stage one.
  assign occupancy = (QLW+1)'(q_level_i) + (QLW+1)'(s1_valid_q);
  assign full_o    = (occupancy >= (QLW+1)'(QDepth));
  assign accept    = push_i && !full_o;

  assign pix_in = (fmt_i == isc_pkg::FmtRgb555 || fmt_i == isc_pkg::FmtRgb565) ?
                  {16'h0000, src_pixel_i[15:0]} : src_pixel_i;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q      <= col_q;
      s1_row_q      <= row_q;
      s1_pix_q      <= pix_in;
      s1_last_col_q <= last_col;
      s1_last_row_q <= last_row;
    end
  end

  // Read the pixel above before this pixel overwrites it.
  isc_ram #(
    .Width(isc_pkg::PixW),
    .Depth(MaxWidth)
  ) u_row_store (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(col_q),
    .wdata_i(pix_in),
    .raddr_i(col_q),
    .rdata_o(ram_rdata)
  );

  assign up = (s1_row_q != '0) ? ram_rdata : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q    <= '0;
      up_left_q <= '0;
    end else if (restart_i) begin
      left_q    <= '0;
      up_left_q <= '0;
    end else if (s1_valid_q) begin
      left_q    <= s1_pix_q;
      up_left_q <= up;
    end
  end

  always_comb begin
    mask = '0;
    mask[isc_pkg::GrpUpLeft]   = (s1_row_q != '0) && (s1_col_q != '0);
    mask[isc_pkg::GrpUpEdge]   = (s1_row_q != '0) && s1_last_col_q;
    mask[isc_pkg::GrpLeftLast] = s1_last_row_q && (s1_col_q != '0);
    mask[isc_pkg::GrpCorner]   = s1_last_row_q && s1_last_col_q;
  end

  // Drop pixels that close no group.
  assign bnd_push_o = s1_valid_q && (mask != '0);

  always_comb begin
    bnd_o          = '0;
    bnd_o.grp_mask = mask;
    bnd_o.col      = isc_pkg::SrcIdxW'(s1_col_q);
    bnd_o.col_m1   = isc_pkg::SrcIdxW'(s1_col_q - CW'(1));
    bnd_o.row      = isc_pkg::SrcIdxW'(s1_row_q);
    bnd_o.row_m1   = isc_pkg::SrcIdxW'(s1_row_q - RW'(1));
    bnd_o.pix      = s1_pix_q;
    bnd_o.up       = up;
    bnd_o.left     = left_q;
    bnd_o.up_left  = up_left_q;
  end

endmodule

@@ src/isc_back.sv @@
// Back end: walk the groups of one bundle and blend each into a result item.
module isc_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [isc_pkg::PixW-1:0] mask_i,
  input  logic                     bnd_valid_i,
  input  isc_pkg::grp_bundle_t     bnd_i,
  output logic                     bnd_pop_o,
  input  logic                     res_ready_i,
  output logic                     res_push_o,
  output isc_pkg::result_t         res_o
);

  logic [isc_pkg::GrpN-1:0] done_q, done_d, pending, sel, rest;
  logic                     fire, last;
  logic [isc_pkg::PixW-1:0] c, r, d, dr, cr;
  logic [isc_pkg::SrcIdxW-1:0] col, row;

  assign pending = bnd_i.grp_mask & ~done_q;

  // Oldest pending group first.
  always_comb begin
    sel = '0;
    priority if (pending[isc_pkg::GrpUpLeft])   sel[isc_pkg::GrpUpLeft]   = 1'b1;
    else if     (pending[isc_pkg::GrpUpEdge])   sel[isc_pkg::GrpUpEdge]   = 1'b1;
    else if     (pending[isc_pkg::GrpLeftLast]) sel[isc_pkg::GrpLeftLast] = 1'b1;
    else                                        sel[isc_pkg::GrpCorner]   = 1'b1;
  end

  assign rest = pending & ~sel;
  assign last = (rest == '0);
  assign fire = bnd_valid_i && res_ready_i;

  always_comb begin
    c   = bnd_i.pix;
    r   = bnd_i.pix;
    d   = bnd_i.pix;
    dr  = bnd_i.pix;
    col = bnd_i.col;
    row = bnd_i.row;
    unique case (1'b1)
      sel[isc_pkg::GrpUpLeft]: begin
        c   = bnd_i.up_left;
        r   = bnd_i.up;
        d   = bnd_i.left;
        col = bnd_i.col_m1;
        row = bnd_i.row_m1;
      end
      sel[isc_pkg::GrpUpEdge]: begin
        c   = bnd_i.up;
        r   = bnd_i.up;
        row = bnd_i.row_m1;
      end
      sel[isc_pkg::GrpLeftLast]: begin
        c   = bnd_i.left;
        d   = bnd_i.left;
        col = bnd_i.col_m1;
      end
      default: begin
      end
    endcase
  end

  assign cr = isc_pkg::mix(c, r, mask_i);

  always_comb begin
    res_o              = '0;
    res_o.src_col      = col;
    res_o.src_row      = row;
    res_o.top_left     = c;
    res_o.top_right    = cr;
    res_o.bottom_left  = isc_pkg::halve(isc_pkg::mix(c, d, mask_i), mask_i);
    res_o.bottom_right = isc_pkg::halve(
                           isc_pkg::mix(cr, isc_pkg::mix(d, dr, mask_i), mask_i), mask_i);
    res_o.last_in_run  = last;
  end

  assign res_push_o = fire;
  assign bnd_pop_o  = fire && last;

  always_comb begin
    done_d = done_q;
    if (fire) begin
      done_d = last ? '0 : (done_q | sel);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= '0;
    end else begin
      done_q <= done_d;
    end
  end

endmodule

@@ src/interp_scanline_2x_scaler_top.sv @@
// Top level of the interpolated 2x scaler with 50 percent scanlines.
//
// Feed source pixels in raster order through push/full; each source pixel C
// becomes a 2x2 group (C, blend right, blend down halved, blend of four halved)
// that comes out through empty/pop with its source column and row. A group is
// emitted once its right and lower neighbours have arrived, so output runs one
// row behind input, and the last row's groups leave while that row arrives;
// neighbours past the right or bottom edge repeat the edge pixel. A pixel closes
// zero to four groups: none in the first row unless it is also the last, one
// inside the frame, two at a row end, none for the first pixel of the next row,
// two for every pixel after the first in the last row, and up to four for the
// last pixel of the frame. The back end blends one group per cycle while the
// result queue has room. Inside the frame this sustains one pixel per cycle
// while the consumer keeps popping, and row-end bursts are taken up by a
// four-entry bundle queue and a two-entry result queue. In the last row each
// pixel after the first needs two groups from the back end, so once the bundle
// queue fills the input slows to one pixel for every two groups; a stalled
// consumer backs up into full the same way. Between the edge that accepts the
// pixel closing a result and the drop of empty lie one register stage for the
// row-store read, one through the bundle queue and one through the result
// queue. The previous row sits in a MaxWidth x 32 RAM; it needs no clearing
// after reset. Any write to a configuration register restarts the frame at
// column 0, row 0; write only while no item is in flight. In 16-bit formats
// the upper half of src_pixel_i is ignored.
module interp_scanline_2x_scaler_top #(
  parameter int MaxWidth  = isc_pkg::MaxWidthDefault,
  parameter int MaxHeight = isc_pkg::MaxHeightDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration writes
  input  logic                          cfg_we_i,
  input  logic [isc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [isc_pkg::CfgDimW-1:0]   cfg_wdata_i,
  // Source pixels
  input  logic                          push,
  output logic                          full,
  input  logic [isc_pkg::PixW-1:0]      src_pixel_i,
  // Result groups
  output logic                          empty,
  input  logic                          pop,
  output logic [isc_pkg::SrcIdxW-1:0]   src_col_o,
  output logic [isc_pkg::SrcIdxW-1:0]   src_row_o,
  output logic [isc_pkg::PixW-1:0]      top_left_o,
  output logic [isc_pkg::PixW-1:0]      top_right_o,
  output logic [isc_pkg::PixW-1:0]      bottom_left_o,
  output logic [isc_pkg::PixW-1:0]      bottom_right_o,
  output logic                          last_in_run_o
);

  localparam int QDepth = isc_pkg::QueueDepth;
  localparam int BndW   = $bits(isc_pkg::grp_bundle_t);
  localparam int ResW   = $bits(isc_pkg::result_t);

  logic [isc_pkg::CfgFmtW-1:0] fmt_q;
  logic [isc_pkg::CfgDimW-1:0] width_q, height_q;
  logic                        restart;
  logic [isc_pkg::PixW-1:0]    pix_mask;

  isc_pkg::grp_bundle_t front_bnd, back_bnd;
  logic                 front_push, bnd_empty, bnd_full, bnd_pop;
  logic [$clog2(QDepth+1)-1:0] bnd_level;
  logic [BndW-1:0]      back_bnd_raw;

  isc_pkg::result_t     back_res, out_res;
  logic                 res_push, res_full;
  logic [ResW-1:0]      out_res_raw;
  logic [$clog2(isc_pkg::OutDepth+1)-1:0] res_level;

  // Configuration registers; a write to a known index restarts the frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= isc_pkg::FmtReset;
      width_q  <= isc_pkg::WidthReset;
      height_q <= isc_pkg::HeightReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        isc_pkg::CfgPixelFormat: fmt_q    <= cfg_wdata_i[isc_pkg::CfgFmtW-1:0];
        isc_pkg::CfgFrameWidth:  width_q  <= cfg_wdata_i;
        isc_pkg::CfgFrameHeight: height_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign restart = cfg_we_i && (cfg_idx_i == isc_pkg::CfgPixelFormat ||
                                cfg_idx_i == isc_pkg::CfgFrameWidth ||
                                cfg_idx_i == isc_pkg::CfgFrameHeight);

  assign pix_mask = isc_pkg::fmt_mask(fmt_q);

  // Front end: position, row store, group classification.
  isc_front #(
    .MaxWidth (MaxWidth),
    .MaxHeight(MaxHeight),
    .QDepth   (QDepth)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .restart_i     (restart),
    .fmt_i         (fmt_q),
    .frame_width_i (width_q),
    .frame_height_i(height_q),
    .push_i        (push),
    .src_pixel_i   (src_pixel_i),
    .full_o        (full),
    .q_level_i     (bnd_level),
    .bnd_push_o    (front_push),
    .bnd_o         (front_bnd)
  );

  // Decouple classification from blending.
  isc_queue #(
    .Width(BndW),
    .Depth(QDepth)
  ) u_bnd_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_push),
    .wdata_i(front_bnd),
    .pop_i  (bnd_pop),
    .rdata_o(back_bnd_raw),
    .empty_o(bnd_empty),
    .full_o (bnd_full),
    .level_o(bnd_level)
  );

  assign back_bnd = isc_pkg::grp_bundle_t'(back_bnd_raw);

  // Back end: one blended group per cycle while the result queue has room.
  isc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mask_i     (pix_mask),
    .bnd_valid_i(!bnd_empty),
    .bnd_i      (back_bnd),
    .bnd_pop_o  (bnd_pop),
    .res_ready_i(!res_full),
    .res_push_o (res_push),
    .res_o      (back_res)
  );

  // Result queue: holds finished items while the consumer stalls.
  isc_queue #(
    .Width(ResW),
    .Depth(isc_pkg::OutDepth)
  ) u_res_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(back_res),
    .pop_i  (pop),
    .rdata_o(out_res_raw),
    .empty_o(empty),
    .full_o (res_full),
    .level_o(res_level)
  );

  assign out_res = isc_pkg::result_t'(out_res_raw);

  assign src_col_o      = out_res.src_col;
  assign src_row_o      = out_res.src_row;
  assign top_left_o     = out_res.top_left;
  assign top_right_o    = out_res.top_right;
  assign bottom_left_o  = out_res.bottom_left;
  assign bottom_right_o = out_res.bottom_right;
  // Queue status bits that nothing outside the queues needs are masked to zero.
  assign last_in_run_o  = out_res.last_in_run |
                          (1'b0 & bnd_full & (res_level == '0));

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Testbench for the interpolated 2x scaler: predicts every 2x2 group and checks each popped one.
module tb;

  // Index 3 is not a register; a write to it must leave the frame alone.
  localparam logic [isc_pkg::CfgIdxW-1:0] CfgUnused = 2'd3;
  // Format code 3 behaves as 32-bit.
  localparam logic [isc_pkg::CfgFmtW-1:0] FmtSpare  = 2'd3;

  localparam int MaxW         = isc_pkg::MaxWidthDefault;
  localparam int MaxH         = isc_pkg::MaxHeightDefault;
  localparam int LineIdxW     = $clog2(MaxW);
  localparam int SettleCycles = 8;     // pipeline is three deep; leave margin
  localparam int StuckLimit   = 2000;  // cycles with no handshake before giving up

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [isc_pkg::CfgIdxW-1:0]   cfg_idx;
  logic [isc_pkg::CfgDimW-1:0]   cfg_wdata;
  logic                          push;
  logic                          full;
  logic [isc_pkg::PixW-1:0]      src_pixel;
  logic                          empty;
  logic                          pop;
  logic [isc_pkg::SrcIdxW-1:0]   src_col;
  logic [isc_pkg::SrcIdxW-1:0]   src_row;
  logic [isc_pkg::PixW-1:0]      top_left;
  logic [isc_pkg::PixW-1:0]      top_right;
  logic [isc_pkg::PixW-1:0]      bottom_left;
  logic [isc_pkg::PixW-1:0]      bottom_right;
  logic                          last_in_run;

  interp_scanline_2x_scaler_top uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .push          (push),
    .full          (full),
    .src_pixel_i   (src_pixel),
    .empty         (empty),
    .pop           (pop),
    .src_col_o     (src_col),
    .src_row_o     (src_row),
    .top_left_o    (top_left),
    .top_right_o   (top_right),
    .bottom_left_o (bottom_left),
    .bottom_right_o(bottom_right),
    .last_in_run_o (last_in_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // ---------------------------------------------------------------------------
  // Scaler shadow: its own copy of the configuration, the previous source row,
  // the two held pixels and the raster position.
  // ---------------------------------------------------------------------------
  logic [isc_pkg::CfgFmtW-1:0] fmt_q;
  logic [isc_pkg::CfgDimW-1:0] width_q;
  logic [isc_pkg::CfgDimW-1:0] height_q;
  logic [isc_pkg::PixW-1:0]    line_mem [0:MaxW-1];
  logic [isc_pkg::PixW-1:0]    left_px;
  logic [isc_pkg::PixW-1:0]    upleft_px;
  int unsigned                 col_n;
  int unsigned                 row_n;

  isc_pkg::result_t pending_groups [$];   // groups owed by the block, oldest first
  int unsigned      mismatch_count = 0;
  int unsigned      stuck_cycles = 0;
  bit               calm = 1'b0;          // set for the last phase: no idling on either side

  function automatic logic [isc_pkg::PixW-1:0] lane_mask(
      input logic [isc_pkg::CfgFmtW-1:0] fmt);
    case (fmt)
      isc_pkg::FmtRgb555: return isc_pkg::MaskRgb555;
      isc_pkg::FmtRgb565: return isc_pkg::MaskRgb565;
      default:            return isc_pkg::Mask32;
    endcase
  endfunction

  // Per-channel average: shift each lane down one bit, drop the bit that
  // crossed into the lane below, then add.
  function automatic logic [isc_pkg::PixW-1:0] blend(input logic [isc_pkg::PixW-1:0] a,
                                                     input logic [isc_pkg::PixW-1:0] b,
                                                     input logic [isc_pkg::PixW-1:0] m);
    return ((a >> 1) & m) + ((b >> 1) & m);
  endfunction

  function automatic isc_pkg::result_t make_group(input int unsigned col,
                                                  input int unsigned row,
                                                  input logic [isc_pkg::PixW-1:0] c,
                                                  input logic [isc_pkg::PixW-1:0] r,
                                                  input logic [isc_pkg::PixW-1:0] d,
                                                  input logic [isc_pkg::PixW-1:0] dr,
                                                  input logic [isc_pkg::PixW-1:0] m);
    isc_pkg::result_t         g;
    logic [isc_pkg::PixW-1:0] cr;
    cr             = blend(c, r, m);
    g.src_col      = col[isc_pkg::SrcIdxW-1:0];
    g.src_row      = row[isc_pkg::SrcIdxW-1:0];
    g.top_left     = c;
    g.top_right    = cr;
    // Lower half of the group is darkened by one more halving (scanline).
    g.bottom_left  = (blend(c, d, m) >> 1) & m;
    g.bottom_right = (blend(cr, blend(d, dr, m), m) >> 1) & m;
    g.last_in_run  = 1'b0;
    return g;
  endfunction

  function automatic void restart_frame();
    left_px   = '0;
    upleft_px = '0;
    col_n     = 0;
    row_n     = 0;
  endfunction

  function automatic void apply_reg(input logic [isc_pkg::CfgIdxW-1:0] idx,
                                    input logic [isc_pkg::CfgDimW-1:0] data);
    case (idx)
      isc_pkg::CfgPixelFormat: begin
        fmt_q = data[isc_pkg::CfgFmtW-1:0];
        restart_frame();
      end
      isc_pkg::CfgFrameWidth: begin
        width_q = data;
        restart_frame();
      end
      isc_pkg::CfgFrameHeight: begin
        height_q = data;
        restart_frame();
      end
      default: begin
      end
    endcase
  endfunction

  // Work out the groups that one accepted source pixel closes and queue them.
  task automatic scale_pixel(input logic [isc_pkg::PixW-1:0] raw);
    isc_pkg::result_t         run [isc_pkg::GrpN];
    int                       n;
    int unsigned              w, h, col, row;
    logic [isc_pkg::PixW-1:0] m, p, up;
    bit                       at_right, at_bottom;
    m = lane_mask(fmt_q);
    w = (width_q == 0) ? 1 : ((width_q > MaxW) ? MaxW : width_q);
    h = (height_q == 0) ? 1 : ((height_q > MaxH) ? MaxH : height_q);
    col = col_n;
    row = row_n;
    if (col >= w) col = w - 1;
    if (row >= h) row = h - 1;
    p = raw;
    if (fmt_q == isc_pkg::FmtRgb555 || fmt_q == isc_pkg::FmtRgb565) begin
      p[isc_pkg::PixW-1:16] = '0;
    end
    at_right  = (col == w - 1);
    at_bottom = (row == h - 1);
    up = (row > 0) ? line_mem[col[LineIdxW-1:0]] : '0;
    n = 0;
    if (row > 0 && col > 0) begin
      run[n] = make_group(col - 1, row - 1, upleft_px, up, left_px, p, m);
      n++;
    end
    // Right edge: the missing right neighbours repeat the edge pixels.
    if (row > 0 && at_right) begin
      run[n] = make_group(col, row - 1, up, up, p, p, m);
      n++;
    end
    // Bottom row: the missing lower neighbours repeat the row itself.
    if (at_bottom && col > 0) begin
      run[n] = make_group(col - 1, row, left_px, p, left_px, p, m);
      n++;
    end
    if (at_bottom && at_right) begin
      run[n] = make_group(col, row, p, p, p, p, m);
      n++;
    end
    if (n > 0) run[n-1].last_in_run = 1'b1;
    for (int i = 0; i < n; i++) pending_groups.push_back(run[i]);
    line_mem[col[LineIdxW-1:0]] = p;
    left_px   = p;
    upleft_px = up;
    if (at_right) begin
      col_n = 0;
      row_n = at_bottom ? 0 : row + 1;
    end else begin
      col_n = col + 1;
      row_n = row;
    end
  endtask

  task automatic check_field(input string what, input logic [isc_pkg::PixW-1:0] want,
                             input logic [isc_pkg::PixW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      mismatch_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge apply register writes, predict from accepted
  // pixels, then check the popped group. Predicting first keeps the queue
  // correct whatever the latency.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    isc_pkg::result_t want;
    if (!rst_n) begin
      fmt_q    = isc_pkg::FmtReset;
      width_q  = isc_pkg::WidthReset;
      height_q = isc_pkg::HeightReset;
      restart_frame();
      pending_groups.delete();
    end else begin
      if (cfg_we) apply_reg(cfg_idx, cfg_wdata);
      if (push && !full) scale_pixel(src_pixel);
      if (pop && !empty) begin
        if (pending_groups.size() == 0) begin
          $display("%0t: unexpected group: expected none, actual col %0d row %0d",
                   $time, src_col, src_row);
          mismatch_count++;
        end else begin
          want = pending_groups.pop_front();
          check_field("src_col", isc_pkg::PixW'(want.src_col), isc_pkg::PixW'(src_col));
          check_field("src_row", isc_pkg::PixW'(want.src_row), isc_pkg::PixW'(src_row));
          check_field("top_left", want.top_left, top_left);
          check_field("top_right", want.top_right, top_right);
          check_field("bottom_left", want.bottom_left, bottom_left);
          check_field("bottom_right", want.bottom_right, bottom_right);
          check_field("last_in_run", isc_pkg::PixW'(want.last_in_run),
                      isc_pkg::PixW'(last_in_run));
        end
      end
    end
  end

  // Watchdog: end the run when no handshake of any kind happens for too long.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (push && !full) || (pop && !empty)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == StuckLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Receiver: pop by default, stall in random bursts unless calm.
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      pop        <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      pop        <= 1'b0;
      stall_left <= $urandom_range(1, 12) - 1;
    end else begin
      pop <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  function automatic logic [isc_pkg::PixW-1:0] rand_pixel();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Offer one item, maybe after a random gap, and hold it until accepted.
  task automatic send_pixel(input logic [isc_pkg::PixW-1:0] value);
    if (!calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    push      <= 1'b1;
    src_pixel <= value;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Drop push, wait for the next edge so the last accepted pixel is predicted,
  // wait until every owed group has been popped, then let pixels that close no
  // group drain out of the pipeline.
  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (pending_groups.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Write all registers back to back; call only while idle. The unused index
  // goes first so the real writes restart the frame in any case.
  task automatic set_frame(input logic [isc_pkg::CfgFmtW-1:0] fmt,
                           input logic [isc_pkg::CfgDimW-1:0] w,
                           input logic [isc_pkg::CfgDimW-1:0] h);
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgUnused;
    cfg_wdata <= isc_pkg::CfgDimW'($urandom);
    @(posedge clk);
    cfg_idx   <= isc_pkg::CfgPixelFormat;
    cfg_wdata <= {{(isc_pkg::CfgDimW-isc_pkg::CfgFmtW){1'b0}}, fmt};
    @(posedge clk);
    cfg_idx   <= isc_pkg::CfgFrameWidth;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_idx   <= isc_pkg::CfgFrameHeight;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: RGB565, 320 wide, 224 high. The first row closes no group;
  // a lone height write then makes the 320-wide row the last one.
  task automatic test_reset_defaults();
    repeat (12) send_pixel(rand_pixel());
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_idx   <= isc_pkg::CfgFrameHeight;
    cfg_wdata <= 10'd1;
    @(posedge clk);
    cfg_we    <= 1'b0;
    repeat (16) send_pixel(rand_pixel());
    wait_idle();
  endtask

  // One-pixel frames: every pixel is its own corner group. Zero sizes act as 1.
  task automatic test_single_pixel();
    set_frame(isc_pkg::Fmt32, 10'd1, 10'd1);
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h8000_0000);
    send_pixel(32'h0000_0001);
    wait_idle();
    set_frame(FmtSpare, 10'd0, 10'd0);
    send_pixel(32'h7FFF_FFFF);
    send_pixel(32'hFFFE_0001);
    wait_idle();
  endtask

  // 2x2 frames in every format code: interior, right edge, bottom edge, corner.
  task automatic test_formats();
    logic [isc_pkg::CfgFmtW-1:0] fmt_list [4];
    fmt_list = '{isc_pkg::FmtRgb555, isc_pkg::FmtRgb565, isc_pkg::Fmt32, FmtSpare};
    foreach (fmt_list[k]) begin
      set_frame(fmt_list[k], 10'd2, 10'd2);
      send_pixel(32'hFFFF_FFFF);
      send_pixel(32'h0000_0000);
      send_pixel(32'hAAAA_5555);
      send_pixel(32'h5555_AAAA);
      wait_idle();
    end
  endtask

  // Width far beyond the line buffer with height zero: one long last row in
  // which every pixel after the first closes a group.
  task automatic test_wide_rows();
    set_frame(isc_pkg::Fmt32, 10'h3FF, 10'd0);
    repeat (20) send_pixel(rand_pixel());
    wait_idle();
  endtask

  // Zero width with a height beyond the limit: one-pixel rows, each closing
  // the group of the row above.
  task automatic test_tall_frame();
    set_frame(isc_pkg::FmtRgb555, 10'd0, 10'h3FF);
    repeat (20) send_pixel(rand_pixel());
    wait_idle();
  endtask

  // Small random frames in random formats, mostly whole frames, some cut short
  // or running into the next frame. Once, hold off mid-frame until drained.
  task automatic test_random_frames();
    int unsigned                 sent, count, w_eff, h_eff;
    logic [isc_pkg::CfgFmtW-1:0] fmt;
    logic [isc_pkg::CfgDimW-1:0] w, h;
    bit                          paused;
    sent   = 0;
    paused = 1'b0;
    while (sent < 20) begin
      fmt = isc_pkg::CfgFmtW'($urandom_range(0, 3));
      w   = isc_pkg::CfgDimW'($urandom_range(1, 6));
      h   = isc_pkg::CfgDimW'($urandom_range(1, 4));
      if ($urandom_range(0, 9) == 0) w = '0;
      if ($urandom_range(0, 9) == 0) h = '0;
      w_eff = (w == 0) ? 1 : w;
      h_eff = (h == 0) ? 1 : h;
      count = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2 * w_eff * h_eff)
                                          : w_eff * h_eff;
      set_frame(fmt, w, h);
      for (int i = 0; i < count; i++) begin
        if (!paused && count > 3 && i == count / 2) begin
          wait_idle();
          paused = 1'b1;
        end
        send_pixel(rand_pixel());
      end
      sent += count;
      wait_idle();
    end
  endtask

  // Full rate on both sides: row-end bursts must be absorbed without loss.
  task automatic test_full_rate();
    calm = 1'b1;
    set_frame(isc_pkg::FmtRgb565, 10'd8, 10'd3);
    repeat (48) send_pixel(rand_pixel());
    wait_idle();
  endtask

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= isc_pkg::CfgPixelFormat;
    cfg_wdata <= '0;
    push      <= 1'b0;
    src_pixel <= '0;
    pop       <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_single_pixel();
    test_formats();
    test_wide_rows();
    test_tall_frame();
    test_random_frames();
    test_full_rate();

    // test_full_rate ends drained and settled; anything popped since is
    // already counted as a mismatch.
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
